[design/aoi_pkg.sv]
// Shared types, widths and constants for the bicycle-model odometry integrator.
// No dependencies; imported by every design module of the block.
package aoi_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_N       = 24;
  localparam int IT_W         = $clog2(ATAN_N);
  localparam int ASH          = 32 - ANGLE_BITS;
  localparam int Z_W          = ANGLE_BITS + 1;
  localparam int XY_W         = 34;
  localparam int TRIG_W       = XY_W - 14;
  localparam int NUM_W        = TRIG_W + 16;
  localparam int DCNT_W       = $clog2(NUM_W);

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int IN_W      = 48;
  localparam int OUT_W     = 208;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MPP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IWB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd2;

  localparam logic signed [XY_W-1:0]    CORDIC_X0    = XY_W'(652032874);
  localparam logic signed [MUL_B_W-1:0] TURN_PER_RAD = MUL_B_W'(683565276);

  localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Arctangent of 2^-i as a binary angle, rounded to the CORDIC angle width.
  function automatic logic signed [Z_W-1:0] atan_step(input logic [IT_W-1:0] idx);
    logic [32:0] v;
    v = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (ASH - 1));
    return Z_W'(v >> ASH);
  endfunction

  typedef enum logic [3:0] {
    OP_STEER, OP_DIST, OP_DX, OP_DY, OP_TAN, OP_DTH, OP_STEP, OP_VX, OP_VY, OP_YAW
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    logic    cordic_go;
    logic    div_go;
    logic    mul_go;
    mul_op_t op;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
  } stat_t;

endpackage

[design/aoi_cordic.sv]
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle, Q4.16.
// One micro-rotation per cycle; depends on aoi_pkg.
module aoi_cordic import aoi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [ANGLE_BITS-1:0]    angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  localparam logic signed [XY_W-1:0] RND14 = XY_W'(8192);

  logic signed [XY_W-1:0] x_r, y_r, xs, ys, xo, yo, xr, yr;
  logic signed [Z_W-1:0]  z_r, at;
  logic [1:0]             q_r;
  logic [IT_W-1:0]        cnt_r;
  logic                   busy_r, done_r;

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = atan_step(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        done_r <= (cnt_r == IT_W'(CORDIC_STEPS - 1));
        if (cnt_r == IT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= CORDIC_X0;
      y_r <= '0;
      z_r <= Z_W'(angle[ANGLE_BITS-3:0]);
      q_r <= angle[ANGLE_BITS-1 -: 2];
    end else if (busy_r) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  // fold the quadrant back in, then round Q4.30 down to Q4.16
  always_comb begin
    case (q_r)
      2'd1: begin xo = -y_r; yo = x_r;  end
      2'd2: begin xo = -x_r; yo = -y_r; end
      2'd3: begin xo = y_r;  yo = -x_r; end
      default: begin xo = x_r; yo = y_r; end
    endcase
    xr = (xo + RND14) >>> 14;
    yr = (yo + RND14) >>> 14;
  end

  assign cos_o = xr[TRIG_W-1:0];
  assign sin_o = yr[TRIG_W-1:0];
  assign done  = done_r;

endmodule

[design/aoi_dp.sv]
// Datapath: config registers, pose state, shared multiplier, tangent divider,
// two CORDIC units and the result register. Depends on aoi_pkg, aoi_cordic.
module aoi_dp import aoi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic [IN_W-1:0]      in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [OUT_W-1:0]     out_data
);

  localparam logic signed [PROD_W-1:0] SMAX  = PROD_W'(2147483647);
  localparam logic signed [PROD_W-1:0] SMIN  = -SMAX - 1;
  localparam logic signed [PROD_W-1:0] RND8  = PROD_W'(128);
  localparam logic signed [PROD_W-1:0] RND12 = PROD_W'(2048);
  localparam logic signed [PROD_W-1:0] RND13 = PROD_W'(4096);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] RND32 = PROD_W'(1) <<< 31;
  localparam logic signed [31:0]       TMAX  = 32'sh7FFFFFFF;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > SMAX) return 32'sh7FFFFFFF;
    else if (v < SMIN) return 32'sh80000000;
    else return v[31:0];
  endfunction

  logic [23:0] mpp_r;
  logic [15:0] iwb_r;
  logic [9:0]  rate_r;

  logic [31:0]              prev_r, acc_x_r, acc_y_r, seq_r;
  logic [15:0]              head_r, step_r;
  logic signed [31:0]       delta_r, dist_r, tan_r, t_r, dth_r, vx_r, vy_r, yaw_r;
  logic signed [15:0]       steer_r;
  logic [ANGLE_BITS-1:0]    steer_ang_r;
  logic signed [MUL_A_W-1:0] dx_r, dy_r;
  logic [OUT_W-1:0]         out_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r, r8, r12, r13, r16, r32;
  mul_op_t                   wb_op_r;
  logic                      wb_r;

  logic [31:0] head32, acc_x_nxt, acc_y_nxt;
  logic [15:0] head_nxt;

  logic                     done_h, done_s;
  logic signed [TRIG_W-1:0] cos_h, sin_h, cos_s, sin_s;

  // tangent divider
  logic [TRIG_W-1:0]  den_r, rem_r, abs_c, abs_s;
  logic [NUM_W-1:0]   num_r;
  logic [TRIG_W:0]    cat;
  logic [TRIG_W+1:0]  trial;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               dbusy_r, dfin_r, ddone_r, neg_r;
  logic [31:0]        qmag;

  assign head32 = {head_r, 16'h0000};

  aoi_cordic u_cordic_head (
    .clk, .rst_n, .go(cmd.cordic_go), .angle(head32[31 -: ANGLE_BITS]),
    .done(done_h), .cos_o(cos_h), .sin_o(sin_h)
  );

  aoi_cordic u_cordic_steer (
    .clk, .rst_n, .go(cmd.cordic_go), .angle(steer_ang_r),
    .done(done_s), .cos_o(cos_s), .sin_o(sin_s)
  );

  assign stat.cordic_done = done_h & done_s;
  assign stat.div_done    = ddone_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r  <= 24'd16777;
      iwb_r  <= 16'd15754;
      rate_r <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MPP:  mpp_r  <= cfg_wdata;
        CFG_IWB:  iwb_r  <= cfg_wdata[15:0];
        CFG_RATE: rate_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_STEER: begin mul_a = MUL_A_W'(steer_r); mul_b = TURN_PER_RAD; end
      OP_DIST:  begin mul_a = MUL_A_W'(delta_r); mul_b = MUL_B_W'($signed({1'b0, mpp_r})); end
      OP_DX:    begin mul_a = MUL_A_W'(dist_r);  mul_b = MUL_B_W'(cos_h); end
      OP_DY:    begin mul_a = MUL_A_W'(dist_r);  mul_b = MUL_B_W'(sin_h); end
      OP_TAN:   begin mul_a = MUL_A_W'(dist_r);  mul_b = MUL_B_W'(tan_r); end
      OP_DTH:   begin mul_a = MUL_A_W'(t_r);     mul_b = MUL_B_W'($signed({1'b0, iwb_r})); end
      OP_STEP:  begin mul_a = MUL_A_W'(dth_r);   mul_b = TURN_PER_RAD; end
      OP_VX:    begin mul_a = dx_r;              mul_b = MUL_B_W'($signed({1'b0, rate_r})); end
      OP_VY:    begin mul_a = dy_r;              mul_b = MUL_B_W'($signed({1'b0, rate_r})); end
      OP_YAW:   begin mul_a = MUL_A_W'(dth_r);   mul_b = MUL_B_W'($signed({1'b0, rate_r})); end
      default:  begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  assign r8  = (prod_r + RND8)  >>> 8;
  assign r12 = (prod_r + RND12) >>> 12;
  assign r13 = (prod_r + RND13) >>> 13;
  assign r16 = (prod_r + RND16) >>> 16;
  assign r32 = (prod_r + RND32) >>> 32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 1'b0;
    end else begin
      wb_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    wb_op_r <= cmd.op;
    if (cmd.capture) begin
      delta_r <= in_data[31:0] - prev_r;
      steer_r <= in_data[47:32];
    end
    if (wb_r) begin
      case (wb_op_r)
        OP_STEER: steer_ang_r <= r13[31 -: ANGLE_BITS];
        OP_DIST:  dist_r <= sat32(r8);
        OP_DX:    dx_r   <= r16[MUL_A_W-1:0];
        OP_DY:    dy_r   <= r16[MUL_A_W-1:0];
        OP_TAN:   t_r    <= sat32(r16);
        OP_DTH:   dth_r  <= sat32(r12);
        OP_STEP:  step_r <= r32[15:0];
        OP_VX:    vx_r   <= sat32(prod_r);
        OP_VY:    vy_r   <= sat32(prod_r);
        OP_YAW:   yaw_r  <= sat32(prod_r);
        default: ;
      endcase
    end
  end

  // restoring divide of |sin| * 2^16 by |cos|, one quotient bit a cycle
  assign abs_c = cos_s[TRIG_W-1] ? TRIG_W'(-cos_s) : TRIG_W'(cos_s);
  assign abs_s = sin_s[TRIG_W-1] ? TRIG_W'(-sin_s) : TRIG_W'(sin_s);
  assign cat   = {rem_r, num_r[NUM_W-1]};
  assign trial = {1'b0, cat} - {2'b00, den_r};
  assign qmag  = (num_r > NUM_W'(TMAX)) ? TMAX : num_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dfin_r  <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      if (cmd.div_go) begin
        dcnt_r  <= '0;
        dfin_r  <= 1'b0;
        // zero cosine skips the divide
        ddone_r <= (cos_s == '0);
        dbusy_r <= (cos_s != '0);
      end else if (dbusy_r) begin
        dcnt_r  <= dcnt_r + 1'b1;
        ddone_r <= 1'b0;
        dfin_r  <= (dcnt_r == DCNT_W'(NUM_W - 1));
        if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
          dbusy_r <= 1'b0;
        end
      end else begin
        ddone_r <= dfin_r;
        dfin_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      den_r <= abs_c;
      num_r <= {abs_s, 16'h0000};
      rem_r <= '0;
      neg_r <= sin_s[TRIG_W-1] ^ cos_s[TRIG_W-1];
      if (cos_s == '0) begin
        tan_r <= sin_s[TRIG_W-1] ? -TMAX : TMAX;
      end
    end else if (dbusy_r) begin
      if (!trial[TRIG_W+1]) begin
        rem_r <= trial[TRIG_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= cat[TRIG_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end else if (dfin_r) begin
      tan_r <= neg_r ? -$signed(qmag) : $signed(qmag);
    end
  end

  // pose state and result
  assign acc_x_nxt = acc_x_r + dx_r[31:0];
  assign acc_y_nxt = acc_y_r + dy_r[31:0];
  assign head_nxt  = head_r + step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      head_r  <= '0;
      seq_r   <= '0;
    end else begin
      if (cmd.capture) prev_r <= in_data[31:0];
      if (cmd.commit) begin
        acc_x_r <= acc_x_nxt;
        acc_y_r <= acc_y_nxt;
        head_r  <= head_nxt;
        seq_r   <= seq_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= {seq_r, yaw_r, vy_r, vx_r, head_nxt, acc_y_nxt, acc_x_nxt};
    end
  end

  assign out_data = out_r;

endmodule

[design/aoi_ctrl.sv]
// Controller: sequences multiplies, CORDIC, divider and result hand-off.
// Depends on aoi_pkg; drives the datapath through cmd_t, reads stat_t.
module aoi_ctrl import aoi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CORD, S_DIV, S_DONE} state_t;

  state_t  state_r;
  mul_op_t op_r;
  logic    ph_r, out_valid_r;
  cmd_t    cmd_r, cmd_nxt;
  logic    accept, commit;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign commit     = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd         = cmd_r;
    cmd.capture = accept;
    cmd.commit  = commit;
  end

  always_comb begin
    cmd_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt.mul_go = 1'b1;
          cmd_nxt.op     = OP_STEER;
        end
      end
      S_MUL: begin
        if (ph_r) begin
          if (op_r == OP_DIST) begin
            cmd_nxt.cordic_go = 1'b1;
          end else if (op_r != OP_YAW) begin
            cmd_nxt.mul_go = 1'b1;
            cmd_nxt.op     = mul_op_t'(op_r + 1'b1);
          end
        end
      end
      S_CORD: begin
        if (stat.cordic_done) cmd_nxt.div_go = 1'b1;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd_nxt.mul_go = 1'b1;
          cmd_nxt.op     = OP_DX;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_STEER;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
    end else begin
      cmd_r <= cmd_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MUL;
            op_r    <= OP_STEER;
            ph_r    <= 1'b0;
          end
        end
        S_MUL: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (op_r == OP_DIST) begin
            state_r <= S_CORD;
          end else if (op_r == OP_YAW) begin
            state_r <= S_DONE;
          end else begin
            // advance to the next product once this one is written back
            op_r <= mul_op_t'(op_r + 1'b1);
            ph_r <= 1'b0;
          end
        end
        S_CORD: begin
          if (stat.cordic_done) state_r <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_done) begin
            state_r <= S_MUL;
            op_r    <= OP_DX;
            ph_r    <= 1'b0;
          end
        end
        S_DONE: begin
          if (commit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ackermann_odometry_integrator_unit.sv]
// Bicycle-model dead-reckoning odometry integrator, top level.
// Depends on aoi_pkg, aoi_ctrl, aoi_dp.
//
// Usage:
//   in_*  : one beat per sample period, tacho count and steering angle.
//   out_* : one beat per input beat: pose, world-frame velocities, yaw rate
//           and a sequence number starting at zero.
//   cfg_* : write meters_per_pulse, inv_wheelbase, sample_rate_hz while idle.
// The 16-step CORDIC pair (heading and steering) and the one-bit-a-cycle
//   tangent divider (36 steps) set most of the time from input beat to result
//   beat; the rest is ten products through one shared multiplier. One sample
//   is in work at a time, so a new beat is taken only once the last is done.
// in_tready is high only while idle; a result waits in the output register
//   while the next sample is taken, and the next result holds in the
//   datapath until the receiver takes the previous one.
// Reset (rst_n low, synchronous) clears pose, sequence, the last tacho count
//   and loads the default configuration.
module ackermann_odometry_integrator_unit import aoi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // tacho_count[31:0], steer_angle[47:32]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], vel_x[111:80], vel_y[143:112],
  // yaw_rate[175:144], sequence_res[207:176]
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  aoi_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd
  );

  aoi_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_data(in_tdata), .cmd, .stat, .out_data(out_tdata)
  );

endmodule

[design/aoi_checker.sv]
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on aoi_pkg.
module aoi_checker import aoi_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before sample finished");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared right after input beat");

endmodule

bind ackermann_odometry_integrator_unit aoi_checker u_aoi_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for ackermann_odometry_integrator_unit.
// Depends on aoi_pkg and the design; predicts every pose beat from its own model.
`timescale 1ns / 100ps

module testbench;
  import aoi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint TURN_RAD = 64'sd683565276;
  localparam longint MAX32 = 64'sd2147483647;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;    // tacho_count[31:0], steer_angle[47:32]
  logic out_tvalid;
  logic out_tready;
  // pos_x, pos_y, heading, vel_x, vel_y, yaw_rate, sequence_res (from bit 0 up)
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  ackermann_odometry_integrator_unit u_dut (.*);

  // shadow configuration and pose state
  logic [23:0] mpp;
  logic [15:0] iwb;
  logic [9:0] rate_hz;
  logic [31:0] prev_count, pose_x, pose_y, seq_no;
  logic [15:0] yaw_ang;

  logic [OUT_W-1:0] pose_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  int fld_lo[7] = '{0, 32, 64, 80, 112, 144, 176};
  int fld_w[7] = '{32, 32, 16, 32, 32, 32, 32};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint rshift_rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > MAX32) return MAX32;
    if (v < -MAX32 - 1) return -MAX32 - 1;
    return v;
  endfunction

  // cos and sin of a 32-bit binary angle in Q16.16
  task automatic cordic_trig(input logic [31:0] ang, output longint c, output longint s);
    logic [15:0] a;
    longint x, y, z, at, xs, ys, tmp;
    a = ang[31:16];
    z = longint'(a[13:0]);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      at = (longint'(ATAN_TURN32[i]) + (64'sd1 <<< 15)) >>> 16;
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= at;
      end else begin
        x += ys; y -= xs; z += at;
      end
    end
    case (a[15:14])
      2'd1: begin tmp = x; x = -y; y = tmp; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin tmp = x; x = y; y = -tmp; end
      default: ;
    endcase
    c = rshift_rnd(x, 14);
    s = rshift_rnd(y, 14);
  endtask

  // advance the dead-reckoning pose by one sample and return the expected beat
  task automatic integrate_sample(input logic [31:0] tacho, input logic [15:0] steer,
                                  output logic [OUT_W-1:0] pose);
    longint delta, dstep, ch, sh, cs, ss, tanv, dx, dy, t, dth, stp;
    logic [31:0] d32, steer_ang;
    d32 = tacho - prev_count;
    delta = longint'($signed(d32));
    dstep = clamp32(rshift_rnd(delta * longint'(mpp), 8));
    cordic_trig({yaw_ang, 16'h0}, ch, sh);
    steer_ang = 32'(rshift_rnd(longint'($signed(steer)) * TURN_RAD, 13));
    cordic_trig(steer_ang, cs, ss);
    if (cs == 0) begin
      tanv = (ss >= 0) ? MAX32 : -MAX32;
    end else begin
      tanv = (ss * 65536) / cs;
      if (tanv > MAX32) tanv = MAX32;
      if (tanv < -MAX32) tanv = -MAX32;
    end
    dx = rshift_rnd(dstep * ch, 16);
    dy = rshift_rnd(dstep * sh, 16);
    pose_x = pose_x + 32'(dx);
    pose_y = pose_y + 32'(dy);
    t = clamp32(rshift_rnd(dstep * tanv, 16));
    dth = clamp32(rshift_rnd(t * longint'(iwb), 12));
    stp = rshift_rnd(dth * TURN_RAD, 32);
    yaw_ang = yaw_ang + 16'(stp);
    pose = {seq_no, 32'(clamp32(dth * longint'(rate_hz))),
            32'(clamp32(dy * longint'(rate_hz))), 32'(clamp32(dx * longint'(rate_hz))),
            yaw_ang, pose_y, pose_x};
    seq_no = seq_no + 1;
    prev_count = tacho;
  endtask

  task automatic send_sample(input logic [31:0] tacho, input logic [15:0] steer);
    logic [OUT_W-1:0] pose;
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {steer, tacho};
    do @(posedge clk); while (!in_tready);
    integrate_sample(tacho, steer, pose);
    pose_q.push_back(pose);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MPP: mpp = val;
      CFG_IWB: iwb = val[15:0];
      CFG_RATE: rate_hz = val[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] m, input logic [15:0] w, input logic [9:0] r);
    cfg_write(CFG_MPP, m);
    cfg_write(CFG_IWB, {8'h0, w});
    cfg_write(CFG_RATE, {14'h0, r});
  endtask

  // mostly smooth driving: small tacho steps, bounded steering; some raw noise
  task automatic random_drive(input int n);
    logic [31:0] tk;
    logic [15:0] st;
    tk = prev_count;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin tk = $urandom; st = $urandom; end
        1: begin tk = tk + $urandom_range(65535); st = $urandom; end
        default: begin
          tk = tk + 32'($signed($urandom_range(400)) - 200);
          st = 16'($signed($urandom_range(8000)) - 4000);
        end
      endcase
      send_sample(tk, st);
    end
  endtask

  task automatic test_directed();
    logic [15:0] steers[10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd12868, -16'sd12868,
                                16'd25736, 16'h0001, 16'hFFFF, 16'd12867, 16'd12869};
    logic [31:0] tks[10] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                             32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0064, 32'h0001_0000,
                             32'hFFFF_0000, 32'h7FFF_FFFF};
    calm = 1;
    for (int i = 0; i < 10; i++) send_sample(tks[i], steers[i]);
    calm = 0;
    drain();
    // extremes of the mpp and iwb registers, a high rate; the unused index must be dropped
    set_config(24'hFF_FFFF, 16'hFFFF, 10'd1000);
    cfg_write(CFG_UNUSED, 24'hAB_CDEF);
    for (int i = 0; i < 10; i++) send_sample(tks[9 - i], steers[i]);
    drain();
  endtask

  task automatic test_random();
    set_config(24'd16777, 16'd15754, 10'd10);
    random_drive(250);
    calm = 1;
    random_drive(100);
    calm = 0;
    drain();
    set_config(24'd0, 16'd1, 10'd1);
    random_drive(60);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_config($urandom, 16'($urandom_range(65535, 1)), 10'($urandom_range(1000, 1)));
      random_drive(80);
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_config(24'd40000, 16'd20000, 10'd100);
    hold_req = 1;
    random_drive(150);
    drain();
  endtask

  // result side
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt <= 600;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pose_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, got %h", $time, out_tdata);
      end else begin
        want = pose_q.pop_front();
        for (int f = 0; f < 7; f++) begin
          if (((want >> fld_lo[f]) & ((208'd1 << fld_w[f]) - 1)) !=
              ((out_tdata >> fld_lo[f]) & ((208'd1 << fld_w[f]) - 1))) begin
            errors++;
            $display("%0t: field %0d expected %h got %h", $time, f,
                     32'(want >> fld_lo[f]), 32'(out_tdata >> fld_lo[f]));
          end
        end
      end
    end
  end

  // watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mpp = 24'd16777;
    iwb = 16'd15754;
    rate_hz = 10'd10;
    prev_count = '0;
    pose_x = '0;
    pose_y = '0;
    yaw_ang = '0;
    seq_no = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[ackermann_odometry_integrator_unit.f]
design/aoi_pkg.sv
design/aoi_cordic.sv
design/aoi_dp.sv
design/aoi_ctrl.sv
design/ackermann_odometry_integrator_unit.sv
design/aoi_checker.sv
verif/testbench.sv
